/* rtl/tdpd_pkg.sv */
// Shared types and constants for the two-phase distance exit detector.
// No dependencies; used by every module in rtl/.
package tdpd_pkg;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_EVAL   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_RUNNING = 2'd1,
		ST_SUCCESS = 2'd2,
		ST_FAILURE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_EXITING  = 2'd1,
		EV_OFF_RAIL = 2'd2
	} event_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_WAIT_LOW = 2'd1,
		PH_EXITING  = 2'd2
	} phase_t;

	// register indexes on the configuration port
	localparam logic [2:0] REG_EXIT_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_OUT_THRESHOLD  = 3'd1;
	localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd2;
	localparam logic [2:0] REG_STALE_TICKS    = 3'd3;
	localparam logic [2:0] REG_EXIT_CONFIRM   = 3'd4;
	localparam logic [2:0] REG_OUT_CONFIRM    = 3'd5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int DIST_W     = 16;
	localparam int AGE_W      = 16;
	localparam int ELAPSED_W  = 24;
	localparam int COUNT_W    = 8;

	// reset values: 120 mm, 160 mm in 1/16 mm; 0.5 s of 1 ms ticks
	localparam logic [DIST_W-1:0]    EXIT_THRESHOLD_RST = 16'd1920;
	localparam logic [DIST_W-1:0]    OUT_THRESHOLD_RST  = 16'd2560;
	localparam logic [ELAPSED_W-1:0] TIMEOUT_TICKS_RST  = 24'd0;
	localparam logic [AGE_W-1:0]     STALE_TICKS_RST    = 16'd500;
	localparam logic [COUNT_W-1:0]   EXIT_CONFIRM_RST   = 8'd2;
	localparam logic [COUNT_W-1:0]   OUT_CONFIRM_RST    = 8'd3;

	typedef struct packed {
		logic [DIST_W-1:0]    exit_threshold;
		logic [DIST_W-1:0]    out_threshold;
		logic [ELAPSED_W-1:0] timeout_ticks;
		logic [AGE_W-1:0]     stale_ticks;
		logic [COUNT_W-1:0]   exit_confirm;
		logic [COUNT_W-1:0]   out_confirm;
	} cfg_t;

	typedef struct packed {
		cmd_t              command;
		logic [DIST_W-1:0] distance;
		logic              sample_bad;
	} item_t;

	typedef struct packed {
		status_t status;
		event_t  rail_event;
	} result_t;

endpackage

/* rtl/two_phase_distance_exit_detector_unit.sv */
// Top level of the two-phase distance exit detector: stream ports, input and
// result registers. Depends on tdpd_pkg, tdpd_cfg and tdpd_core.
//
//   channel   dir   handshake                 payload
//   s_*       in    s_tvalid / s_tready       tdata: distance; tuser: command, sample_bad
//   m_*       out   m_tvalid / m_tready       tdata: status, rail_event
//   cfg_*     in    cfg_we (no back-pressure) cfg_index, cfg_data
//
// One command per clock sustained while m_tready stays high. A transfer lands
// in the input register (_s1); once the result register is free or being
// drained, the core runs it, updates the detector state and loads the result
// register (_s2), from which the result is offered. The result register
// is the only stall point: while m_tready is low and a result waits, a
// command in the input register holds there and s_tready drops.
// arst_n clears valids, detector state and restores register defaults.
module two_phase_distance_exit_detector_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [15:0]                       s_tdata,   // [15:0] distance
	input  logic [2:0]                        s_tuser,   // [1:0] command, [2] sample_bad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [7:0]                        m_tdata,   // [1:0] status, [3:2] rail_event, zero
	input  logic                              cfg_we,
	input  logic [tdpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tdpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	tdpd_pkg::cfg_t    cfg;
	tdpd_pkg::item_t   item_s1;
	tdpd_pkg::result_t res_c;
	tdpd_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              adv;

	// item in s1 moves on when the result slot is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command    <= tdpd_pkg::cmd_t'(s_tuser[1:0]);
			item_s1.sample_bad <= s_tuser[2];
			item_s1.distance   <= s_tdata;
		end
	end

	tdpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// state commits only when the command's result is loaded
	tdpd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, res_s2.rail_event, res_s2.status};

	// off-rail is only ever announced together with success
	a_offrail_success: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.rail_event == tdpd_pkg::EV_OFF_RAIL)
		|-> (res_s2.status == tdpd_pkg::ST_SUCCESS))
		else $error("off-rail event without success status");

	// EXITING is announced while the run continues
	a_exiting_running: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.rail_event == tdpd_pkg::EV_EXITING)
		|-> (res_s2.status == tdpd_pkg::ST_RUNNING))
		else $error("EXITING without running status");

	// a blocked command stays in the input register untouched
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a blocked command");

	// a result only leaves the output register through a transfer
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |=> valid_s2 && $stable(res_s2))
		else $error("result dropped while stalled");

endmodule

/* rtl/tdpd_cfg.sv */
// Configuration register file for the exit detector.
// Depends on tdpd_pkg.
module tdpd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tdpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tdpd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tdpd_pkg::cfg_t                    cfg
);

	tdpd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exit_threshold <= tdpd_pkg::EXIT_THRESHOLD_RST;
			cfg_q.out_threshold  <= tdpd_pkg::OUT_THRESHOLD_RST;
			cfg_q.timeout_ticks  <= tdpd_pkg::TIMEOUT_TICKS_RST;
			cfg_q.stale_ticks    <= tdpd_pkg::STALE_TICKS_RST;
			cfg_q.exit_confirm   <= tdpd_pkg::EXIT_CONFIRM_RST;
			cfg_q.out_confirm    <= tdpd_pkg::OUT_CONFIRM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdpd_pkg::REG_EXIT_THRESHOLD: cfg_q.exit_threshold <= cfg_data[15:0];
				tdpd_pkg::REG_OUT_THRESHOLD:  cfg_q.out_threshold  <= cfg_data[15:0];
				tdpd_pkg::REG_TIMEOUT_TICKS:  cfg_q.timeout_ticks  <= cfg_data;
				tdpd_pkg::REG_STALE_TICKS:    cfg_q.stale_ticks    <= cfg_data[15:0];
				tdpd_pkg::REG_EXIT_CONFIRM:   cfg_q.exit_confirm   <= cfg_data[7:0];
				tdpd_pkg::REG_OUT_CONFIRM:    cfg_q.out_confirm    <= cfg_data[7:0];
				default: ; // unused indexes are dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/tdpd_core.sv */
// Detector state and per-command update logic; one command per enabled cycle.
// Depends on tdpd_pkg.
module tdpd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  tdpd_pkg::item_t   item,
	input  tdpd_pkg::cfg_t    cfg,
	output tdpd_pkg::result_t res
);

	tdpd_pkg::phase_t                    phase_q, phase_d;
	logic [tdpd_pkg::COUNT_W-1:0]        low_count_q, low_count_d;
	logic [tdpd_pkg::COUNT_W-1:0]        high_count_q, high_count_d;
	logic [tdpd_pkg::DIST_W-1:0]         latest_q, latest_d;
	logic                                have_q, have_d;
	logic [tdpd_pkg::AGE_W-1:0]          age_q, age_d;
	logic [tdpd_pkg::ELAPSED_W-1:0]      elapsed_q, elapsed_d;

	logic                                cfg_bad;
	logic                                running;
	logic                                timed_out;
	logic                                fresh;
	logic [tdpd_pkg::COUNT_W-1:0]        low_inc, high_inc;

	assign cfg_bad = (cfg.exit_threshold == '0) ||
		(cfg.out_threshold <= cfg.exit_threshold) ||
		(cfg.stale_ticks == '0) || (cfg.exit_confirm == '0) ||
		(cfg.out_confirm == '0);
	assign running   = (phase_q == tdpd_pkg::PH_WAIT_LOW) || (phase_q == tdpd_pkg::PH_EXITING);
	assign timed_out = (cfg.timeout_ticks != '0) && (elapsed_q >= cfg.timeout_ticks);
	assign fresh     = have_q && (age_q <= cfg.stale_ticks);
	// saturating increments of the run counters
	assign low_inc   = (&low_count_q) ? low_count_q : low_count_q + 1'b1;
	assign high_inc  = (&high_count_q) ? high_count_q : high_count_q + 1'b1;

	always_comb begin
		phase_d        = phase_q;
		low_count_d    = low_count_q;
		high_count_d   = high_count_q;
		latest_d       = latest_q;
		have_d         = have_q;
		age_d          = age_q;
		elapsed_d      = elapsed_q;
		res.status     = tdpd_pkg::ST_NONE;
		res.rail_event = tdpd_pkg::EV_NONE;
		unique case (item.command)
			tdpd_pkg::CMD_START: begin
				if (cfg_bad) begin
					phase_d    = tdpd_pkg::PH_IDLE;
					res.status = tdpd_pkg::ST_FAILURE;
				end else begin
					phase_d      = tdpd_pkg::PH_WAIT_LOW;
					low_count_d  = '0;
					high_count_d = '0;
					elapsed_d    = '0;
					res.status   = tdpd_pkg::ST_RUNNING;
				end
			end
			tdpd_pkg::CMD_SAMPLE: begin
				if (!item.sample_bad) begin
					latest_d = item.distance;
					age_d    = '0;
					have_d   = 1'b1;
				end
			end
			tdpd_pkg::CMD_TICK: begin
				age_d     = (&age_q) ? age_q : age_q + 1'b1;
				elapsed_d = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
			end
			tdpd_pkg::CMD_EVAL: begin
				if (!running) begin
					res.status = tdpd_pkg::ST_NONE;
				end else if (timed_out) begin
					phase_d    = tdpd_pkg::PH_IDLE;
					res.status = tdpd_pkg::ST_FAILURE;
				end else begin
					res.status = tdpd_pkg::ST_RUNNING;
					if (fresh) begin
						if (phase_q == tdpd_pkg::PH_WAIT_LOW) begin
							low_count_d = (latest_q <= cfg.exit_threshold) ? low_inc : '0;
							if (low_count_d >= cfg.exit_confirm) begin
								res.rail_event = tdpd_pkg::EV_EXITING;
								phase_d        = tdpd_pkg::PH_EXITING;
								high_count_d   = '0;
							end
						end else begin
							high_count_d = (latest_q >= cfg.out_threshold) ? high_inc : '0;
							if (high_count_d >= cfg.out_confirm) begin
								res.rail_event = tdpd_pkg::EV_OFF_RAIL;
								res.status     = tdpd_pkg::ST_SUCCESS;
								phase_d        = tdpd_pkg::PH_IDLE;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= tdpd_pkg::PH_IDLE;
			low_count_q  <= '0;
			high_count_q <= '0;
			latest_q     <= '0;
			have_q       <= 1'b0;
			age_q        <= '0;
			elapsed_q    <= '0;
		end else if (en) begin
			phase_q      <= phase_d;
			low_count_q  <= low_count_d;
			high_count_q <= high_count_d;
			latest_q     <= latest_d;
			have_q       <= have_d;
			age_q        <= age_d;
			elapsed_q    <= elapsed_d;
		end
	end

endmodule

/* test/testbench.sv */
// Self-checking testbench for two_phase_distance_exit_detector_unit: directed and random
// command streams with a cycle-free detector model that predicts every status/event report.
// Depends on rtl/tdpd_pkg.sv and the unit under test; needs no files or arguments.
module testbench;

	logic clk;
	logic arst_n = 1'b0;

	// stream in: tdata = distance, tuser = {sample_bad, command}
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;

	// stream out: tdata = {zero, rail_event, status}
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;

	logic cfg_we = 1'b0;
	logic [tdpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tdpd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// idle rates in percent, changed between test stages
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int items_sent = 0;
	int errors = 0;

	// reports still owed by the unit, oldest first
	tdpd_pkg::result_t due_reports[$];
	tdpd_pkg::result_t got_due;

	// detector model: register shadow plus run state
	tdpd_pkg::cfg_t cfg_shadow = '{tdpd_pkg::EXIT_THRESHOLD_RST, tdpd_pkg::OUT_THRESHOLD_RST,
		tdpd_pkg::TIMEOUT_TICKS_RST, tdpd_pkg::STALE_TICKS_RST, tdpd_pkg::EXIT_CONFIRM_RST,
		tdpd_pkg::OUT_CONFIRM_RST};
	tdpd_pkg::phase_t det_phase = tdpd_pkg::PH_IDLE;
	logic [tdpd_pkg::COUNT_W-1:0] low_cnt = '0;
	logic [tdpd_pkg::COUNT_W-1:0] high_cnt = '0;
	logic [tdpd_pkg::DIST_W-1:0] held_dist = '0;
	logic held_valid = 1'b0;
	logic [tdpd_pkg::AGE_W-1:0] held_age = '0;
	logic [tdpd_pkg::ELAPSED_W-1:0] run_ticks = '0;

	two_phase_distance_exit_detector_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the detector model by one command and return the report it owes.
	function automatic tdpd_pkg::result_t detector_next(input tdpd_pkg::cmd_t cmd,
			input logic [15:0] dist_val, input logic bad);
		tdpd_pkg::result_t r;
		r.status = tdpd_pkg::ST_NONE;
		r.rail_event = tdpd_pkg::EV_NONE;
		case (cmd)
		tdpd_pkg::CMD_START: begin
			// settings are vetted on every start; a bad set leaves the detector idle
			if (cfg_shadow.exit_threshold == 0 ||
					cfg_shadow.out_threshold <= cfg_shadow.exit_threshold ||
					cfg_shadow.stale_ticks == 0 || cfg_shadow.exit_confirm == 0 ||
					cfg_shadow.out_confirm == 0) begin
				det_phase = tdpd_pkg::PH_IDLE;
				r.status = tdpd_pkg::ST_FAILURE;
			end else begin
				// held sample and its age survive a start
				det_phase = tdpd_pkg::PH_WAIT_LOW;
				low_cnt = '0;
				high_cnt = '0;
				run_ticks = '0;
				r.status = tdpd_pkg::ST_RUNNING;
			end
		end
		tdpd_pkg::CMD_SAMPLE: begin
			if (!bad) begin
				held_dist = dist_val;
				held_age = '0;
				held_valid = 1'b1;
			end
		end
		tdpd_pkg::CMD_TICK: begin
			// both timers saturate and keep running while idle
			if (held_age != '1)
				held_age = held_age + 1'b1;
			if (run_ticks != '1)
				run_ticks = run_ticks + 1'b1;
		end
		tdpd_pkg::CMD_EVAL: begin
			if (det_phase == tdpd_pkg::PH_WAIT_LOW || det_phase == tdpd_pkg::PH_EXITING) begin
				if (cfg_shadow.timeout_ticks != 0 &&
						run_ticks >= cfg_shadow.timeout_ticks) begin
					det_phase = tdpd_pkg::PH_IDLE;
					r.status = tdpd_pkg::ST_FAILURE;
				end else begin
					r.status = tdpd_pkg::ST_RUNNING;
					// a fresh sample is not consumed: evaluating it again counts again
					if (held_valid && held_age <= cfg_shadow.stale_ticks) begin
						if (det_phase == tdpd_pkg::PH_WAIT_LOW) begin
							if (held_dist <= cfg_shadow.exit_threshold)
								low_cnt = (low_cnt == '1) ? low_cnt : low_cnt + 1'b1;
							else
								low_cnt = '0;
							if (low_cnt >= cfg_shadow.exit_confirm) begin
								r.rail_event = tdpd_pkg::EV_EXITING;
								det_phase = tdpd_pkg::PH_EXITING;
								high_cnt = '0;
							end
						end else begin
							if (held_dist >= cfg_shadow.out_threshold)
								high_cnt = (high_cnt == '1) ? high_cnt : high_cnt + 1'b1;
							else
								high_cnt = '0;
							if (high_cnt >= cfg_shadow.out_confirm) begin
								r.rail_event = tdpd_pkg::EV_OFF_RAIL;
								r.status = tdpd_pkg::ST_SUCCESS;
								det_phase = tdpd_pkg::PH_IDLE;
							end
						end
					end
				end
			end
		end
		endcase
		return r;
	endfunction

	// Offer one command, hold it until the transfer, then book its report.
	task automatic send_item(input tdpd_pkg::cmd_t cmd, input logic [15:0] dist_val,
			input logic bad);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= dist_val;
		s_tuser <= {bad, cmd};
		do
			@(posedge clk);
		while (!s_tready);
		due_reports.push_back(detector_next(cmd, dist_val, bad));
		items_sent++;
	endtask

	// Stop sending until every booked report has come back and the pipe is empty.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write all six registers back to back while the unit is idle.
	task automatic load_settings(input tdpd_pkg::cfg_t c);
		logic [tdpd_pkg::CFG_IDX_W-1:0] idx[6];
		logic [tdpd_pkg::CFG_DATA_W-1:0] val[6];
		idx = '{tdpd_pkg::REG_EXIT_THRESHOLD, tdpd_pkg::REG_OUT_THRESHOLD,
			tdpd_pkg::REG_TIMEOUT_TICKS, tdpd_pkg::REG_STALE_TICKS,
			tdpd_pkg::REG_EXIT_CONFIRM, tdpd_pkg::REG_OUT_CONFIRM};
		val = '{tdpd_pkg::CFG_DATA_W'(c.exit_threshold),
			tdpd_pkg::CFG_DATA_W'(c.out_threshold), c.timeout_ticks,
			tdpd_pkg::CFG_DATA_W'(c.stale_ticks), tdpd_pkg::CFG_DATA_W'(c.exit_confirm),
			tdpd_pkg::CFG_DATA_W'(c.out_confirm)};
		wait_drained();
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg_shadow = c;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Mostly valid settings; zeros, inverted thresholds and range ends now and then.
	function automatic tdpd_pkg::cfg_t random_settings();
		tdpd_pkg::cfg_t c;
		int unsigned o;
		case ($urandom_range(9))
		0: c.exit_threshold = '0;
		1: c.exit_threshold = 16'd1;
		2: c.exit_threshold = 16'hFFFE;
		3: c.exit_threshold = 16'hFFFF;
		default: c.exit_threshold = 16'($urandom_range(4000, 100));
		endcase
		o = c.exit_threshold + $urandom_range(3000, 1);
		if (o > 16'hFFFF)
			o = 16'hFFFF;
		case ($urandom_range(9))
		0: c.out_threshold = 16'($urandom_range(c.exit_threshold, 0));
		1: c.out_threshold = 16'hFFFF;
		default: c.out_threshold = 16'(o);
		endcase
		case ($urandom_range(9))
		0, 1, 2, 3: c.timeout_ticks = '0;
		4: c.timeout_ticks = '1;
		default: c.timeout_ticks = 24'($urandom_range(80, 1));
		endcase
		case ($urandom_range(19))
		0: c.stale_ticks = '0;
		1: c.stale_ticks = '1;
		default: c.stale_ticks = 16'($urandom_range(8, 1));
		endcase
		case ($urandom_range(19))
		0: c.exit_confirm = '0;
		1: c.exit_confirm = '1;
		default: c.exit_confirm = 8'($urandom_range(4, 1));
		endcase
		case ($urandom_range(19))
		0: c.out_confirm = '0;
		1: c.out_confirm = '1;
		default: c.out_confirm = 8'($urandom_range(4, 1));
		endcase
		return c;
	endfunction

	// Distances cluster on the side the run is heading for, with some in between.
	function automatic logic [15:0] pick_distance(input bit want_low);
		int unsigned r;
		r = $urandom_range(9);
		if (r < 7)
			return want_low ? 16'($urandom_range(cfg_shadow.exit_threshold, 0)) :
				16'($urandom_range(16'hFFFF, cfg_shadow.out_threshold));
		else if (r == 7)
			return 16'($urandom_range(cfg_shadow.out_threshold, cfg_shadow.exit_threshold));
		return 16'($urandom);
	endfunction

	// Straight through the nominal flow on reset settings.
	task automatic test_default_run();
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);	// idle: no report content
		send_item(tdpd_pkg::CMD_START, 16'hFFFF, 1'b1);	// start ignores distance and flag
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);	// running, nothing held yet
		send_item(tdpd_pkg::CMD_SAMPLE, 16'hFFFF, 1'b1);	// flagged sample dropped
		send_item(tdpd_pkg::CMD_SAMPLE, 16'h0000, 1'b0);
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);	// same sample counts again: EXITING
		send_item(tdpd_pkg::CMD_SAMPLE, 16'hFFFF, 1'b0);
		send_item(tdpd_pkg::CMD_TICK, 16'h0000, 1'b0);
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);	// off-rail, back to idle
	endtask

	// Each way a start can reject its settings, then the tightest valid thresholds.
	task automatic test_start_checks();
		tdpd_pkg::cfg_t base;
		tdpd_pkg::cfg_t c;
		base = '{16'd1920, 16'd2560, 24'd0, 16'd500, 8'd2, 8'd3};
		for (int i = 0; i < 6; i++) begin
			c = base;
			case (i)
			0: c.exit_threshold = '0;
			1: c.out_threshold = c.exit_threshold;
			2: c.stale_ticks = '0;
			3: c.exit_confirm = '0;
			4: c.out_confirm = '0;
			default: begin
				c.exit_threshold = 16'hFFFE;
				c.out_threshold = 16'hFFFF;
			end
			endcase
			load_settings(c);
			send_item(tdpd_pkg::CMD_START, 16'h0000, 1'b0);
		end
	endtask

	// Whole-run timeout ends a run in failure; an aged sample is skipped.
	task automatic test_timeout_and_stale();
		load_settings('{16'd1, 16'hFFFF, 24'd2, 16'd1, 8'd1, 8'd1});
		send_item(tdpd_pkg::CMD_START, 16'h0000, 1'b0);
		send_item(tdpd_pkg::CMD_SAMPLE, 16'h0001, 1'b0);
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);	// low count hits 1: EXITING
		send_item(tdpd_pkg::CMD_TICK, 16'h0000, 1'b0);
		send_item(tdpd_pkg::CMD_TICK, 16'h0000, 1'b0);
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);	// elapsed reached timeout: failure
		send_item(tdpd_pkg::CMD_START, 16'h0000, 1'b0);	// elapsed cleared, sample age kept
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);	// age 2 > 1: stale
		send_item(tdpd_pkg::CMD_SAMPLE, 16'h0000, 1'b0);
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);
	endtask

	// Sample age right at the limit is still fresh, one tick more is stale.
	task automatic test_age_limit();
		load_settings('{16'd100, 16'd200, 24'd0, 16'd3, 8'd1, 8'd1});
		send_item(tdpd_pkg::CMD_START, 16'h0000, 1'b0);
		send_item(tdpd_pkg::CMD_SAMPLE, 16'd50, 1'b0);
		repeat (3) send_item(tdpd_pkg::CMD_TICK, 16'($urandom), 1'($urandom));
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);	// age 3: fresh, EXITING
		send_item(tdpd_pkg::CMD_TICK, 16'h0000, 1'b0);
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);	// age 4: stale
		send_item(tdpd_pkg::CMD_SAMPLE, 16'd250, 1'b0);
		send_item(tdpd_pkg::CMD_EVAL, 16'h0000, 1'b0);	// fresh and high: off-rail
	endtask

	// Runs of mostly well-formed traffic: settings, start, then samples trending
	// from low to high distance mixed with ticks and evaluations.
	task automatic test_random_runs(input int count);
		int target;
		int run_len;
		int unsigned r;
		bit want_low;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(3) == 0)
				load_settings(random_settings());
			if ($urandom_range(9) != 0)
				send_item(tdpd_pkg::CMD_START, 16'($urandom), 1'($urandom));
			run_len = $urandom_range(60, 8);
			for (int i = 0; i < run_len; i++) begin
				want_low = ($urandom_range(run_len - 1) >= i);
				r = $urandom_range(99);
				if (r < 30)
					send_item(tdpd_pkg::CMD_SAMPLE, pick_distance(want_low), 1'b0);
				else if (r < 36)
					send_item(tdpd_pkg::CMD_SAMPLE, 16'($urandom), 1'b1);
				else if (r < 56)
					send_item(tdpd_pkg::CMD_TICK, 16'($urandom), 1'($urandom));
				else if (r < 97)
					send_item(tdpd_pkg::CMD_EVAL, 16'($urandom), 1'($urandom));
				else
					send_item(tdpd_pkg::CMD_START, 16'($urandom), 1'($urandom));
			end
		end
	endtask

	// Receiver back-pressure, redrawn every cycle.
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Every report transfer is matched against the oldest booked report.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected report, expected none, got status %0d event %0d",
					$time, m_tdata[1:0], m_tdata[3:2]);
			end else begin
				got_due = due_reports.pop_front();
				if (m_tdata[1:0] !== got_due.status ||
						m_tdata[3:2] !== got_due.rail_event) begin
					errors++;
					$display({"%0t: report mismatch, expected status %0d event %0d, ",
						"got status %0d event %0d"}, $time, got_due.status,
						got_due.rail_event, m_tdata[1:0], m_tdata[3:2]);
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// slow sender against a mostly stalled receiver
		set_idling(24, 70);
		test_default_run();
		test_start_checks();
		test_timeout_and_stale();
		test_random_runs(350);

		// bursty receiver, slow sender
		set_idling(70, 24);
		test_random_runs(350);

		// full rate both ways
		set_idling(0, 0);
		test_random_runs(350);
		test_age_limit();

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("two_phase_distance_exit_detector_unit regression: pass");
		else
			$display("two_phase_distance_exit_detector_unit regression: fail");
		$finish;
	end

	// watchdog: several times the slowest legal run
	initial begin
		#5000000;
		$display("two_phase_distance_exit_detector_unit regression: fail");
		$finish;
	end

endmodule

/* two_phase_distance_exit_detector_unit.f */
rtl/tdpd_pkg.sv
rtl/tdpd_cfg.sv
rtl/tdpd_core.sv
rtl/two_phase_distance_exit_detector_unit.sv
test/testbench.sv
